FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is high.
`define IFB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also checks across reset.
`define IFB_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/ifb_pkg.sv
// Types and constants of the information frame builder.
package ifb_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_FLAG     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESCAPE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADDRESS  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CTRL_SEQ0 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CTRL_SEQ1 = 3'd4;

   localparam logic [BYTE_W-1:0] FLAG_RESET      = 8'd126;
   localparam logic [BYTE_W-1:0] ESCAPE_RESET    = 8'd125;
   localparam logic [BYTE_W-1:0] ADDRESS_RESET   = 8'd3;
   localparam logic [BYTE_W-1:0] CTRL_SEQ0_RESET = 8'd0;
   localparam logic [BYTE_W-1:0] CTRL_SEQ1_RESET = 8'd64;

   typedef struct packed {
      logic [BYTE_W-1:0] flag;
      logic [BYTE_W-1:0] escape;
      logic [BYTE_W-1:0] address;
      logic [BYTE_W-1:0] ctrl_seq0;
      logic [BYTE_W-1:0] ctrl_seq1;
   } cfg_type;

   typedef struct packed {
      logic              hdr;
      logic [BYTE_W-1:0] ctrl;
      logic              stuff;
      logic [BYTE_W-1:0] data;
      logic              last;
      logic [BYTE_W-1:0] check;
   } cmd_type;

   typedef enum logic [3:0] {
      STEP_START,
      STEP_FLAG,
      STEP_ADDR,
      STEP_CTRL,
      STEP_HCHK,
      STEP_ESC,
      STEP_DATA,
      STEP_CHK,
      STEP_CLOSE
   } step_type;

endpackage

FILE: src/ifb_front.sv
// Front end: accepts payload beats, classifies them and tracks the frame check.
module ifb_front (
   input  logic                      clock,
   input  logic                      reset,
   input  ifb_pkg::cfg_type          cfg,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [ifb_pkg::BYTE_W-1:0] req_tdata,
   input  logic                      req_tlast,
   input  logic                      req_tuser,
   input  logic                      queue_full,
   output logic                      push,
   output ifb_pkg::cmd_type          push_cmd
);

   logic                       inside_ff;
   logic                       inside_in;
   logic [ifb_pkg::BYTE_W-1:0] check_ff;
   logic [ifb_pkg::BYTE_W-1:0] check_in;
   logic [ifb_pkg::BYTE_W-1:0] check_next;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;
   assign check_next = (inside_ff ? check_ff : '0) ^ req_tdata;

   always_comb begin
      push_cmd.hdr   = !inside_ff;
      push_cmd.ctrl  = req_tuser ? cfg.ctrl_seq1 : cfg.ctrl_seq0;
      push_cmd.stuff = (req_tdata == cfg.flag) || (req_tdata == cfg.escape);
      push_cmd.data  = req_tdata;
      push_cmd.last  = req_tlast;
      push_cmd.check = check_next;
   end

   always_comb begin
      inside_in = inside_ff;
      check_in  = check_ff;
      if (push) begin
         inside_in = !req_tlast;
         check_in  = req_tlast ? '0 : check_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         check_ff  <= '0;
      end else begin
         inside_ff <= inside_in;
         check_ff  <= check_in;
      end
   end

endmodule

FILE: src/ifb_queue.sv
// Short command queue between front and back, head visible without a read cycle.
module ifb_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ifb_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output ifb_pkg::cmd_type head,
   output logic             empty
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   ifb_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign full  = (count_ff == CNT_FULL);
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_MAX) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_MAX) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: src/ifb_back.sv
// Back end: steps through each command and drives the framed output beats.
module ifb_back (
   input  logic                       clock,
   input  logic                       reset,
   input  ifb_pkg::cfg_type           cfg,
   input  logic                       queue_empty,
   input  ifb_pkg::cmd_type           head,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [ifb_pkg::BYTE_W-1:0] rsp_tdata,
   output logic                       rsp_tlast,
   output logic                       rsp_tuser
);

   ifb_pkg::step_type step_ff;
   ifb_pkg::step_type step_in;
   ifb_pkg::step_type first_step;
   ifb_pkg::step_type cur_step;
   ifb_pkg::step_type after_step;

   logic                       fire;
   logic                       cmd_done;
   logic                       frame_end;
   logic [ifb_pkg::BYTE_W-1:0] line_byte;

   logic                       valid_ff;
   logic                       valid_in;
   logic [ifb_pkg::BYTE_W-1:0] data_ff;
   logic [ifb_pkg::BYTE_W-1:0] data_in;
   logic                       last_ff;
   logic                       last_in;
   logic                       user_ff;
   logic                       user_in;

   assign fire = !queue_empty && (!valid_ff || rsp_tready);
   assign pop  = fire && cmd_done;

   always_comb begin
      if (head.hdr) begin
         first_step = ifb_pkg::STEP_FLAG;
      end else if (head.stuff) begin
         first_step = ifb_pkg::STEP_ESC;
      end else begin
         first_step = ifb_pkg::STEP_DATA;
      end
      cur_step = (step_ff == ifb_pkg::STEP_START) ? first_step : step_ff;
   end

   // next step
   always_comb begin
      after_step = ifb_pkg::STEP_START;
      case (cur_step)
         ifb_pkg::STEP_FLAG:  after_step = ifb_pkg::STEP_ADDR;
         ifb_pkg::STEP_ADDR:  after_step = ifb_pkg::STEP_CTRL;
         ifb_pkg::STEP_CTRL:  after_step = ifb_pkg::STEP_HCHK;
         ifb_pkg::STEP_HCHK:  after_step = head.stuff ? ifb_pkg::STEP_ESC : ifb_pkg::STEP_DATA;
         ifb_pkg::STEP_ESC:   after_step = ifb_pkg::STEP_DATA;
         ifb_pkg::STEP_DATA:  after_step = head.last ? ifb_pkg::STEP_CHK : ifb_pkg::STEP_START;
         ifb_pkg::STEP_CHK:   after_step = ifb_pkg::STEP_CLOSE;
         ifb_pkg::STEP_CLOSE: after_step = ifb_pkg::STEP_START;
         default:             after_step = ifb_pkg::STEP_START;
      endcase
      step_in = step_ff;
      if (fire) begin
         step_in = after_step;
      end
   end

   // beat contents
   always_comb begin
      line_byte = head.data;
      frame_end = 1'b0;
      cmd_done  = 1'b0;
      case (cur_step)
         ifb_pkg::STEP_FLAG: line_byte = cfg.flag;
         ifb_pkg::STEP_ADDR: line_byte = cfg.address;
         ifb_pkg::STEP_CTRL: line_byte = head.ctrl;
         ifb_pkg::STEP_HCHK: line_byte = cfg.address ^ head.ctrl;
         ifb_pkg::STEP_ESC:  line_byte = cfg.escape;
         ifb_pkg::STEP_DATA: begin
            line_byte = head.data;
            cmd_done  = !head.last;
         end
         ifb_pkg::STEP_CHK:  line_byte = head.check;
         ifb_pkg::STEP_CLOSE: begin
            line_byte = cfg.flag;
            frame_end = 1'b1;
            cmd_done  = 1'b1;
         end
         default: line_byte = head.data;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      user_in  = user_ff;
      if (fire) begin
         valid_in = 1'b1;
         data_in  = line_byte;
         last_in  = cmd_done;
         user_in  = frame_end;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= ifb_pkg::STEP_START;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
      user_ff <= user_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = user_ff;

endmodule

FILE: src/information_frame_builder.sv
// Information frame builder: byte-stuffing framer with header, check byte and closing flag.
//
// Takes one payload byte per beat and sends the framed line stream one byte per cycle, a rate
// set by the output register, while the receiver is ready. The front end accepts a beat every
// cycle while the command queue (QUEUE_DEPTH entries) has room. An input beat becomes 1 line
// byte for a plain middle byte, plus 1 for an escape, plus 4 for the header on a frame's
// first byte, plus 2 for check byte and closing flag on its last byte (1 to 8 line bytes).
// Configuration registers are written through the csr port, index 0 flag, 1 escape, 2
// address, 3 control for sequence 0, 4 control for sequence 1; other indexes are ignored.
// Write them only while the block is idle.
module information_frame_builder #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // payload_byte
   input  logic                            req_tlast,   // payload_last
   input  logic                            req_tuser,   // sequence_bit
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,   // line_byte
   output logic                            rsp_tlast,   // run_last
   output logic                            rsp_tuser,   // frame_end
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ifb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                      csr_wdata
);

   ifb_pkg::cfg_type cfg_ff;
   ifb_pkg::cfg_type cfg_in;
   ifb_pkg::cmd_type push_cmd;
   ifb_pkg::cmd_type head;
   logic             push;
   logic             pop;
   logic             queue_full;
   logic             queue_empty;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            ifb_pkg::CSR_FLAG:      cfg_in.flag      = csr_wdata;
            ifb_pkg::CSR_ESCAPE:    cfg_in.escape    = csr_wdata;
            ifb_pkg::CSR_ADDRESS:   cfg_in.address   = csr_wdata;
            ifb_pkg::CSR_CTRL_SEQ0: cfg_in.ctrl_seq0 = csr_wdata;
            ifb_pkg::CSR_CTRL_SEQ1: cfg_in.ctrl_seq1 = csr_wdata;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flag      <= ifb_pkg::FLAG_RESET;
         cfg_ff.escape    <= ifb_pkg::ESCAPE_RESET;
         cfg_ff.address   <= ifb_pkg::ADDRESS_RESET;
         cfg_ff.ctrl_seq0 <= ifb_pkg::CTRL_SEQ0_RESET;
         cfg_ff.ctrl_seq1 <= ifb_pkg::CTRL_SEQ1_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ifb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   ifb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .head     (head),
      .empty    (queue_empty)
   );

   ifb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

FILE: src/ifb_checker.sv
// Port-level checks of the information frame builder, bound to the top level.
`include "assert_macros.svh"

module ifb_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   `IFB_ASSERT(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser),
      "rsp beat changed while stalled")
   `IFB_ASSERT(a_end_is_last, clock, reset, rsp_tvalid && rsp_tuser |-> rsp_tlast,
      "closing flag beat not marked last")
   `IFB_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid,
      "rsp beat valid right after reset")

endmodule

bind information_frame_builder ifb_checker u_ifb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

FILE: tb/testbench.sv
// Testbench for the information frame builder: framed line stream checked beat by beat.
`timescale 1ns / 1ps

module testbench;

   localparam int QUIET_LIMIT = 1000;
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_ITEMS = 400;

   typedef struct {
      logic [7:0] line_byte;
      logic       run_last;
      logic       frame_end;
   } line_beat_type;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [7:0]                      req_tdata;   // payload_byte
   logic                            req_tlast;   // payload_last
   logic                            req_tuser;   // sequence_bit
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [7:0]                      rsp_tdata;   // line_byte
   logic                            rsp_tlast;   // run_last
   logic                            rsp_tuser;   // frame_end
   logic                            csr_valid;
   logic                            csr_ready;
   logic [ifb_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [7:0]                      csr_wdata;

   ifb_pkg::cfg_type cfg;
   logic             in_frame;
   logic [7:0]       running_check;
   line_beat_type    line_due[$];
   line_beat_type    want;
   int               mismatch_count;
   int               quiet_cycles;
   int               rsp_hold;
   int               items_sent;
   bit               steady_req;
   bit               steady_rsp;

   information_frame_builder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic int draw_gap(input bit steady);
      if (steady || $urandom_range(0, 1) == 0)
         return 0;
      return $urandom_range(0, 3);
   endfunction

   function automatic void frame_payload_byte(input logic [7:0] b, input logic last,
                                              input logic seq);
      line_beat_type run[8];
      logic [7:0]    ctrl;
      int            n;
      n = 0;
      if (!in_frame) begin
         ctrl = seq ? cfg.ctrl_seq1 : cfg.ctrl_seq0;
         run[n] = '{cfg.flag, 1'b0, 1'b0};
         n++;
         run[n] = '{cfg.address, 1'b0, 1'b0};
         n++;
         run[n] = '{ctrl, 1'b0, 1'b0};
         n++;
         run[n] = '{cfg.address ^ ctrl, 1'b0, 1'b0};
         n++;
         running_check = 8'h00;
         in_frame = 1'b1;
      end
      if (b == cfg.flag || b == cfg.escape) begin
         run[n] = '{cfg.escape, 1'b0, 1'b0};
         n++;
      end
      run[n] = '{b, 1'b0, 1'b0};
      n++;
      running_check = running_check ^ b;
      if (last) begin
         run[n] = '{running_check, 1'b0, 1'b0};
         n++;
         run[n] = '{cfg.flag, 1'b0, 1'b1};
         n++;
         in_frame = 1'b0;
         running_check = 8'h00;
      end
      run[n-1].run_last = 1'b1;
      for (int i = 0; i < n; i++)
         line_due.push_back(run[i]);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last, input logic seq);
      int gap;
      gap = draw_gap(steady_req);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      req_tuser  <= seq;
      do @(posedge clock); while (!req_tready);
      frame_payload_byte(b, last, seq);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (line_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [ifb_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         ifb_pkg::CSR_FLAG:      cfg.flag = value;
         ifb_pkg::CSR_ESCAPE:    cfg.escape = value;
         ifb_pkg::CSR_ADDRESS:   cfg.address = value;
         ifb_pkg::CSR_CTRL_SEQ0: cfg.ctrl_seq0 = value;
         ifb_pkg::CSR_CTRL_SEQ1: cfg.ctrl_seq1 = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all_regs(input logic [7:0] flag, input logic [7:0] escape,
                                 input logic [7:0] address, input logic [7:0] ctrl0,
                                 input logic [7:0] ctrl1);
      write_reg(ifb_pkg::CSR_FLAG, flag);
      write_reg(ifb_pkg::CSR_ESCAPE, escape);
      write_reg(ifb_pkg::CSR_ADDRESS, address);
      write_reg(ifb_pkg::CSR_CTRL_SEQ0, ctrl0);
      write_reg(ifb_pkg::CSR_CTRL_SEQ1, ctrl1);
   endtask

   task automatic test_reset_defaults();
      send_byte(8'h00, 1'b1, 1'b0);
      send_byte(8'hFF, 1'b1, 1'b1);
      send_byte(ifb_pkg::FLAG_RESET, 1'b1, 1'b0);
      send_byte(ifb_pkg::ESCAPE_RESET, 1'b1, 1'b1);
   endtask

   task automatic test_multi_byte_frame();
      send_byte(ifb_pkg::ESCAPE_RESET, 1'b0, 1'b1);
      send_byte(ifb_pkg::FLAG_RESET, 1'b0, 1'b0);
      send_byte(8'h55, 1'b0, 1'b1);
      send_byte(ifb_pkg::FLAG_RESET, 1'b1, 1'b0);
   endtask

   task automatic test_register_extremes();
      wait_drained();
      write_all_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send_byte(8'h00, 1'b1, 1'b0);
      send_byte(8'h01, 1'b1, 1'b1);
      wait_drained();
      write_all_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_byte(8'hFF, 1'b1, 1'b1);
      send_byte(8'h80, 1'b1, 1'b0);
      wait_drained();
      write_all_regs(8'h5A, 8'h5A, 8'hA5, 8'h0F, 8'hF0);
      send_byte(8'h5A, 1'b1, 1'b0);
      send_byte(8'h5A, 1'b0, 1'b1);
      send_byte(8'h5B, 1'b1, 1'b0);
   endtask

   task automatic test_unmapped_index();
      wait_drained();
      write_reg(3'd5, 8'h11);
      write_reg(3'd6, 8'h22);
      write_reg(3'd7, 8'h33);
      send_byte(8'h5A, 1'b1, 1'b1);
   endtask

   task automatic test_write_mid_frame();
      send_byte(8'h11, 1'b0, 1'b1);
      wait_drained();
      write_reg(ifb_pkg::CSR_FLAG, 8'h11);
      write_reg(ifb_pkg::CSR_ESCAPE, 8'h22);
      send_byte(8'h11, 1'b0, 1'b0);
      wait_drained();
      write_reg(ifb_pkg::CSR_ADDRESS, 8'h33);
      send_byte(8'h22, 1'b1, 1'b1);
   endtask

   function automatic logic [7:0] pick_reg_value();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] pick_payload_byte();
      case ($urandom_range(0, 9))
         0, 1: return cfg.flag;
         2: return cfg.escape;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic test_random_frames();
      int frames;
      int len;
      logic [7:0] flag;
      logic seq;
      while (items_sent < RANDOM_ITEMS) begin
         wait_drained();
         flag = pick_reg_value();
         write_all_regs(flag, ($urandom_range(0, 3) == 0) ? flag : pick_reg_value(),
                        pick_reg_value(), pick_reg_value(), pick_reg_value());
         if ($urandom_range(0, 4) == 0)
            write_reg(3'($urandom_range(5, 7)), pick_reg_value());
         steady_req = ($urandom_range(0, 3) == 0);
         steady_rsp = ($urandom_range(0, 3) == 0);
         frames = $urandom_range(2, 8);
         for (int f = 0; f < frames; f++) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            seq = 1'($urandom_range(0, 1));
            for (int i = 0; i < len; i++)
               send_byte(pick_payload_byte(), i == len - 1,
                         (i == 0) ? seq : 1'($urandom_range(0, 1)));
         end
      end
      steady_req = 1'b0;
      steady_rsp = 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (line_due.size() == 0) begin
               report_mismatch($sformatf("line byte %02h with nothing due", rsp_tdata));
            end else begin
               want = line_due.pop_front();
               if (rsp_tdata !== want.line_byte)
                  report_mismatch($sformatf("line_byte %02h, due %02h",
                                            rsp_tdata, want.line_byte));
               if (rsp_tlast !== want.run_last)
                  report_mismatch($sformatf("run_last %b, due %b", rsp_tlast, want.run_last));
               if (rsp_tuser !== want.frame_end)
                  report_mismatch($sformatf("frame_end %b, due %b",
                                            rsp_tuser, want.frame_end));
            end
            rsp_hold = draw_gap(steady_rsp);
         end
         if (rsp_hold > 0) begin
            rsp_hold   <= rsp_hold - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_tvalid     <= 1'b0;
      req_tdata      <= 8'h00;
      req_tlast      <= 1'b0;
      req_tuser      <= 1'b0;
      rsp_tready     <= 1'b0;
      csr_valid      <= 1'b0;
      csr_index      <= ifb_pkg::CSR_FLAG;
      csr_wdata      <= 8'h00;
      cfg            = '{ifb_pkg::FLAG_RESET, ifb_pkg::ESCAPE_RESET, ifb_pkg::ADDRESS_RESET,
                         ifb_pkg::CTRL_SEQ0_RESET, ifb_pkg::CTRL_SEQ1_RESET};
      in_frame       = 1'b0;
      running_check  = 8'h00;
      mismatch_count = 0;
      quiet_cycles   = 0;
      rsp_hold       = 0;
      items_sent     = 0;
      steady_req     = 1'b0;
      steady_rsp     = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_multi_byte_frame();
      test_register_extremes();
      test_unmapped_index();
      test_write_mid_frame();
      items_sent = 0;
      test_random_frames();

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+src
src/ifb_pkg.sv
src/ifb_front.sv
src/ifb_queue.sv
src/ifb_back.sv
src/information_frame_builder.sv
src/ifb_checker.sv
tb/testbench.sv
